// File: rtl/core/pse_pkg.sv
`default_nettype none
package pse_pkg;

   localparam int KEY_BITS   = 32;
   localparam int INDEX_BITS = 48;

   // result queue depth, room for two results of one request plus slack
   localparam int QUEUE_DEPTH = 4;
   localparam int QUEUE_AW    = $clog2(QUEUE_DEPTH);

   typedef struct packed {
      logic                         single_entry;
      logic signed [KEY_BITS-1:0]   key_first;
      logic signed [KEY_BITS-1:0]   key_final;
      logic signed [KEY_BITS-1:0]   key_stride;
      logic        [INDEX_BITS-1:0] index_first;
      logic        [INDEX_BITS-1:0] index_final;
      logic signed [INDEX_BITS-1:0] index_stride;
      logic                         line_done;
   } result_type;

endpackage
`default_nettype wire

// File: rtl/core/progression_segment_encoder.sv
`default_nettype none
// Packs a line of (key, file index) pairs into arithmetic-progression segments.
// Request channel: req_valid/req_stall with one pair per request, req_end_of_line
// on the last pair of a line. Response channel: rsp_valid/rsp_stall, one
// segment per response; rsp_line_done marks the last segment of the line and
// rsp_single_entry a line of one pair.
// Each request is evaluated in the cycle it is accepted against the open
// segment registers (two subtracts, two adds, two compares) and its results are
// written to a four-entry result queue, from whose registers responses are read.
// A request gives zero, one or two responses; the queue drains one per cycle while rsp_stall is low.
// Throughput is one request per cycle while the queue has room for two
// results; req_stall rises when it holds three or more.
// When the receiver stalls, the queue fills and then req_stall is raised;
// nothing is dropped and the shown response holds.
// Reset empties the queue and returns the encoder to the start of a line.
module progression_segment_encoder (
   input  wire                                   clock,
   input  wire                                   reset,
   input  wire                                   req_valid,
   output logic                                  req_stall,
   input  wire  signed [pse_pkg::KEY_BITS-1:0]   req_key,
   input  wire         [pse_pkg::INDEX_BITS-1:0] req_file_index,
   input  wire                                   req_end_of_line,
   output logic                                  rsp_valid,
   input  wire                                   rsp_stall,
   output logic                                  rsp_single_entry,
   output logic signed [pse_pkg::KEY_BITS-1:0]   rsp_key_first,
   output logic signed [pse_pkg::KEY_BITS-1:0]   rsp_key_final,
   output logic signed [pse_pkg::KEY_BITS-1:0]   rsp_key_stride,
   output logic        [pse_pkg::INDEX_BITS-1:0] rsp_index_first,
   output logic        [pse_pkg::INDEX_BITS-1:0] rsp_index_final,
   output logic signed [pse_pkg::INDEX_BITS-1:0] rsp_index_stride,
   output logic                                  rsp_line_done
);
   import pse_pkg::*;

   localparam logic [1:0] PS_START = 2'd0;
   localparam logic [1:0] PS_ONE   = 2'd1;
   localparam logic [1:0] PS_OPEN  = 2'd2;

   logic [1:0]            pairs_seen_ff, pairs_seen_in;
   logic [KEY_BITS-1:0]   key_first_ff, key_first_in;
   logic [KEY_BITS-1:0]   key_final_ff, key_final_in;
   logic [KEY_BITS-1:0]   key_stride_ff, key_stride_in;
   logic [INDEX_BITS-1:0] index_first_ff, index_first_in;
   logic [INDEX_BITS-1:0] index_final_ff, index_final_in;
   logic [INDEX_BITS-1:0] index_stride_ff, index_stride_in;

   logic                  accept;
   logic                  room_two;
   logic [KEY_BITS-1:0]   key_diff;
   logic [INDEX_BITS-1:0] index_diff;
   logic                  on_track;
   logic [1:0]            push_count;
   result_type            push_data0, push_data1, seg_now, seg_old, pop_data;

   assign req_stall = !room_two;
   assign accept    = req_valid && room_two;

   assign key_diff   = req_key - key_final_ff;
   assign index_diff = req_file_index - index_final_ff;
   // a pair stays on the progression when it is one stride past the final
   assign on_track   = (req_key == key_final_ff + key_stride_ff) &&
                       (req_file_index == index_final_ff + index_stride_ff);

   always_comb begin
      pairs_seen_in   = pairs_seen_ff;
      key_first_in    = key_first_ff;
      key_final_in    = key_final_ff;
      key_stride_in   = key_stride_ff;
      index_first_in  = index_first_ff;
      index_final_in  = index_final_ff;
      index_stride_in = index_stride_ff;
      push_count      = 2'd0;

      seg_old = '{single_entry: 1'b0, key_first: key_first_ff, key_final: key_final_ff,
                  key_stride: key_stride_ff, index_first: index_first_ff,
                  index_final: index_final_ff, index_stride: index_stride_ff,
                  line_done: 1'b0};
      push_data0 = seg_old;
      push_data1 = seg_old;

      if (accept) begin
         unique case (pairs_seen_ff)
            PS_START: begin
               key_first_in    = req_key;
               key_final_in    = req_key;
               key_stride_in   = '0;
               index_first_in  = req_file_index;
               index_final_in  = req_file_index;
               index_stride_in = '0;
               pairs_seen_in   = PS_ONE;
            end
            PS_ONE: begin
               key_stride_in   = key_diff;
               index_stride_in = index_diff;
               key_final_in    = req_key;
               index_final_in  = req_file_index;
               pairs_seen_in   = PS_OPEN;
            end
            default: begin
               key_final_in   = req_key;
               index_final_in = req_file_index;
               pairs_seen_in  = PS_OPEN;
               if (!on_track) begin
                  key_stride_in   = key_diff;
                  index_stride_in = index_diff;
                  key_first_in    = req_key;
                  index_first_in  = req_file_index;
                  push_count      = 2'd1;
               end
            end
         endcase
      end

      seg_now = '{single_entry: 1'b0, key_first: key_first_in, key_final: key_final_in,
                  key_stride: key_stride_in, index_first: index_first_in,
                  index_final: index_final_in, index_stride: index_stride_in,
                  line_done: 1'b1};

      if (accept && req_end_of_line) begin
         pairs_seen_in = PS_START;
         if (pairs_seen_ff == PS_START) begin
            push_data0 = '{single_entry: 1'b1, key_first: req_key, key_final: '0,
                           key_stride: '0, index_first: req_file_index,
                           index_final: '0, index_stride: '0, line_done: 1'b1};
            push_count = 2'd1;
         end else if (push_count == 2'd1) begin
            // broken progression on the last pair: closed segment, then the new one
            push_data1 = seg_now;
            push_count = 2'd2;
         end else begin
            push_data0 = seg_now;
            push_count = 2'd1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pairs_seen_ff <= PS_START;
      end else begin
         pairs_seen_ff <= pairs_seen_in;
      end
   end

   always_ff @(posedge clock) begin
      key_first_ff    <= key_first_in;
      key_final_ff    <= key_final_in;
      key_stride_ff   <= key_stride_in;
      index_first_ff  <= index_first_in;
      index_final_ff  <= index_final_in;
      index_stride_ff <= index_stride_in;
   end

   pse_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_count (push_count),
      .push_data0 (push_data0),
      .push_data1 (push_data1),
      .room_two   (room_two),
      .pop_valid  (rsp_valid),
      .pop_stall  (rsp_stall),
      .pop_data   (pop_data)
   );

   assign rsp_single_entry = pop_data.single_entry;
   assign rsp_key_first    = pop_data.key_first;
   assign rsp_key_final    = pop_data.key_final;
   assign rsp_key_stride   = pop_data.key_stride;
   assign rsp_index_first  = pop_data.index_first;
   assign rsp_index_final  = pop_data.index_final;
   assign rsp_index_stride = pop_data.index_stride;
   assign rsp_line_done    = pop_data.line_done;

endmodule
`default_nettype wire

// File: rtl/core/pse_queue.sv
`default_nettype none
module pse_queue (
   input  wire                       clock,
   input  wire                       reset,
   input  wire  [1:0]                push_count,
   input  wire  pse_pkg::result_type push_data0,
   input  wire  pse_pkg::result_type push_data1,
   output logic                      room_two,
   output logic                      pop_valid,
   input  wire                       pop_stall,
   output pse_pkg::result_type       pop_data
);
   import pse_pkg::*;

   result_type            entry_ff [QUEUE_DEPTH];
   logic [QUEUE_AW-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [QUEUE_AW-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [QUEUE_AW:0]     count_ff, count_in;
   logic [QUEUE_AW-1:0]   wr_ptr_next;
   logic                  pop;

   assign wr_ptr_next = wr_ptr_ff + QUEUE_AW'(1);
   assign pop         = pop_valid && !pop_stall;
   assign pop_valid   = (count_ff != '0);
   assign pop_data    = entry_ff[rd_ptr_ff];
   assign room_two    = (count_ff <= (QUEUE_AW+1)'(QUEUE_DEPTH - 2));

   always_comb begin
      wr_ptr_in = wr_ptr_ff + QUEUE_AW'(push_count);
      rd_ptr_in = pop ? rd_ptr_ff + QUEUE_AW'(1) : rd_ptr_ff;
      count_in  = count_ff + (QUEUE_AW+1)'(push_count) - (QUEUE_AW+1)'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push_count != 2'd0) begin
         entry_ff[wr_ptr_ff] <= push_data0;
      end
      if (push_count == 2'd2) begin
         entry_ff[wr_ptr_next] <= push_data1;
      end
   end

endmodule
`default_nettype wire
